@@ rtl/core/fkad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkad_pkg
// Shared widths, register indexes and the per-lane control beat for the
// four key armed debouncer.
// ----------------------------------------------------------------------------
package fkad_pkg;

    // field widths fixed by the interface
    localparam int PIN_W     = 4;
    localparam int MASK_W    = 4;
    localparam int COUNT_W   = 8;
    localparam int EVENT_W   = 3;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH_MASK = 1'b1;

    // register reset values
    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd20;
    localparam logic [MASK_W-1:0]  MASK_RESET     = 4'd1;

    // per-lane control for one tick
    typedef struct packed {
        logic               en;    // tick beat accepted this cycle
        logic               down;  // key reads as pressed
        logic [COUNT_W-1:0] lim;   // debounce time
    } lane_ctrl_t;

endpackage

@@ rtl/core/fkad_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkad_lane
// Debounce state of one key: release and press counters, armed and held
// flags. Raises fire on the tick that completes an armed press.
// ----------------------------------------------------------------------------
module fkad_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  fkad_pkg::lane_ctrl_t ctrl,
    output logic                fire
);

    logic [fkad_pkg::COUNT_W-1:0] press_count_reg, press_count_next;
    logic [fkad_pkg::COUNT_W-1:0] release_count_reg, release_count_next;
    logic                         held_reg, held_next;
    logic                         armed_reg, armed_next;

    always_comb
    begin
        press_count_next   = press_count_reg;
        release_count_next = release_count_reg;
        held_next          = held_reg;
        armed_next         = armed_reg;
        fire               = 1'b0;
        if (!ctrl.down)
        begin
            press_count_next = '0;
            held_next        = 1'b0;
            if (release_count_reg < ctrl.lim)
            begin
                release_count_next = fkad_pkg::COUNT_W'(release_count_reg + 1'b1);
            end
            if (release_count_next >= ctrl.lim)
            begin
                armed_next = 1'b1;
            end
        end
        else
        begin
            release_count_next = '0;
            if (armed_reg)
            begin
                if (press_count_reg < ctrl.lim)
                begin
                    press_count_next = fkad_pkg::COUNT_W'(press_count_reg + 1'b1);
                end
                if (!held_reg && (press_count_next >= ctrl.lim))
                begin
                    held_next = 1'b1;
                    fire      = ctrl.en;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_count_reg   <= '0;
            release_count_reg <= '0;
            held_reg          <= 1'b0;
            armed_reg         <= 1'b0;
        end
        else if (ctrl.en)
        begin
            press_count_reg   <= press_count_next;
            release_count_reg <= release_count_next;
            held_reg          <= held_next;
            armed_reg         <= armed_next;
        end
    end

`ifndef SYNTHESIS
    // a press is only ever latched on an armed key
    assert property (@(posedge clk) disable iff (!rst_n) held_reg |-> armed_reg)
        else $error("fkad_lane: held without armed");
    // fire only on an accepted tick of an armed key
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (ctrl.en && armed_reg && !held_reg))
        else $error("fkad_lane: fire without armed tick");
    // a fired key is held on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) fire |=> held_reg)
        else $error("fkad_lane: fire did not latch held");
`endif

endmodule

@@ rtl/core/fkad_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkad_merge
// Picks the highest key that fired and queues the event code in a
// two-entry output register and skid stage.
// ----------------------------------------------------------------------------
module fkad_merge
#(
    parameter int NUM_KEYS = 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [NUM_KEYS-1:0]          fire,
    output logic                         in_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fkad_pkg::EVENT_W-1:0] press_event
);

    logic [fkad_pkg::EVENT_W-1:0] code;
    logic                         out_valid_reg, out_valid_next;
    logic [fkad_pkg::EVENT_W-1:0] out_data_reg, out_data_next;
    logic                         skid_valid_reg, skid_valid_next;
    logic [fkad_pkg::EVENT_W-1:0] skid_data_reg, skid_data_next;
    logic                         pop;

    // highest key wins, code is key number plus one cut to the field width
    always_comb
    begin
        code = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (fire[k])
            begin
                code = fkad_pkg::EVENT_W'(k + 1);
            end
        end
    end

    assign in_ready    = !skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign press_event = out_data_reg;
    assign pop         = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = code;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef SYNTHESIS
    // the skid stage only fills behind a waiting output
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> out_valid_reg)
        else $error("fkad_merge: skid full with output empty");
    // a beat into an empty queue shows at the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !out_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("fkad_merge: beat lost on empty queue");
    // draining the last entry with nothing new leaves the queue empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && !skid_valid_reg) |=> !out_valid_reg)
        else $error("fkad_merge: beat repeated");
`endif

endmodule

@@ rtl/core/four_key_armed_debouncer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_key_armed_debouncer_top
// Armed key debouncer: one beat per tick in, one event code per tick out.
// ----------------------------------------------------------------------------
// Each input beat is one tick carrying the raw pin levels of the keys; each
// produces exactly one output beat with the event code (0 none, key i gives
// i+1, highest key wins, lower events on the same tick are dropped). A key
// arms after debounce_ticks released ticks and fires once after
// debounce_ticks pressed ticks while armed. The block takes one tick per
// clock cycle while in_ready is high: every key has its own lane that updates
// its counters in the cycle the beat is accepted, and the merge stage
// registers the winning code. A two-entry output queue lets a tick be taken
// while a result still waits; input ready drops only when both entries are
// full. Registers (index 0 debounce_ticks, index 1 active_high_mask) are
// written through cfg_we while the block is idle, a user duty the block
// does not enforce. Keys past the pin width read a low level and low polarity.
// ----------------------------------------------------------------------------
module four_key_armed_debouncer_top
#(
    parameter int NUM_KEYS = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // tick beats
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [fkad_pkg::PIN_W-1:0]     pin_levels,
    // event beats
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [fkad_pkg::EVENT_W-1:0]   press_event,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [fkad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fkad_pkg::CFG_W-1:0]     cfg_data
);

    // configuration registers
    logic [fkad_pkg::COUNT_W-1:0] debounce_ticks_reg;
    logic [fkad_pkg::MASK_W-1:0]  active_high_mask_reg;

    logic                         tick_accept;
    logic [NUM_KEYS-1:0]          fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= fkad_pkg::DEBOUNCE_RESET;
            active_high_mask_reg <= fkad_pkg::MASK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fkad_pkg::REG_DEBOUNCE_TICKS:
                    debounce_ticks_reg <= cfg_data;
                fkad_pkg::REG_ACTIVE_HIGH_MASK:
                    active_high_mask_reg <= cfg_data[fkad_pkg::MASK_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign tick_accept = in_valid && in_ready;

    // one lane per key, all stepping on the same tick
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        fkad_pkg::lane_ctrl_t ctrl;

        assign ctrl.en  = tick_accept;
        assign ctrl.lim = debounce_ticks_reg;
        if (k < fkad_pkg::PIN_W)
        begin : g_pin
            // pressed when the level matches the key's polarity bit
            assign ctrl.down = (pin_levels[k] == active_high_mask_reg[k]);
        end
        else
        begin : g_nopin
            // no pin behind this key: level and polarity both read low
            assign ctrl.down = 1'b1;
        end

        fkad_lane u_lane
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .fire  (fire[k])
        );
    end

    // priority pick and output queue
    fkad_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (tick_accept),
        .fire        (fire),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .press_event (press_event)
    );

endmodule
